// File: hw/rtl/cts_pkg.sv
// shared widths, constants and the pipeline item type of the series cosine
`default_nettype none

package cts_pkg;

    localparam int ANGLE_W   = 32;
    localparam int COS_W     = 32;
    localparam int FRAC_W    = 44;
    localparam int SQ_W      = 2 * ANGLE_W;
    localparam int SQ_SHIFT  = 56 - FRAC_W;
    localparam int Y_W       = 51;
    localparam int MAG_W     = 56;
    localparam int Y_LO_W    = 26;
    localparam int Y_HI_W    = Y_W - Y_LO_W;
    localparam int MAG_LO_W  = 28;
    localparam int MAG_HI_W  = MAG_W - MAG_LO_W;
    localparam int PROD_W    = Y_W + MAG_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int DIG_W     = 21;
    localparam int N_W       = 3 * DIG_W;
    localparam int REM_W     = 10;
    localparam int V_W       = DIG_W + REM_W;
    localparam int RECIP_W   = V_W + 2;
    localparam int PRODV_W   = V_W + RECIP_W;

    localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << FRAC_W;
    localparam logic [N_W-1:0]   ONE_N   = N_W'(1) << FRAC_W;
    localparam logic [COS_W-1:0] MAX_POS = {1'b0, {(COS_W-1){1'b1}}};
    localparam logic [COS_W-1:0] MIN_NEG = {1'b1, {(COS_W-1){1'b0}}};

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [Y_W-1:0]   y;
    } term_t;

endpackage

`default_nettype wire

// File: hw/rtl/cosine_taylor_series.sv
// top level of the pipelined series cosine
//
// Cosine of a Q3.28 angle in radians as the NUM_TERMS term Maclaurin series,
// evaluated by Horner's rule in x squared; result in Q1.30 (OUT_FRAC_BITS
// fraction bits), rounded to nearest and saturated. No range reduction is
// done. One angle is taken every cycle while angle_ready is high. The
// pipe has two stages for the square, eight per Horner step (product,
// rounding, three divider digits with remainders, update) and the output
// register. A result that waits on cosine_ready does not stop the pipe
// at once: one more result parks in a skid slot, and only then is
// angle_ready dropped.
`default_nettype none

module cosine_taylor_series #(
    parameter int NUM_TERMS     = 11,
    parameter int OUT_FRAC_BITS = 30
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        angle_valid,
    output logic                        angle_ready,
    input  logic [cts_pkg::ANGLE_W-1:0] angle,
    output logic                        cosine_valid,
    input  logic                        cosine_ready,
    output logic [cts_pkg::COS_W-1:0]   cosine
);

    logic                     pipe_en;
    cts_pkg::term_t           chain       [NUM_TERMS];
    logic [NUM_TERMS-1:0]     chain_valid;

    cts_square u_square (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (pipe_en),
        .angle_valid (angle_valid),
        .angle       (angle),
        .term        (chain[0]),
        .term_valid  (chain_valid[0])
    );

    for (genvar j = 0; j < NUM_TERMS - 1; j++)
    begin : g_step
        cts_step #(
            .K (NUM_TERMS - 2 - j)
        ) u_step (
            .clk            (clk),
            .rst_n          (rst_n),
            .en             (pipe_en),
            .term_in        (chain[j]),
            .term_in_valid  (chain_valid[j]),
            .term_out       (chain[j+1]),
            .term_out_valid (chain_valid[j+1])
        );
    end

    cts_round #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_round (
        .clk          (clk),
        .rst_n        (rst_n),
        .term         (chain[NUM_TERMS-1]),
        .term_valid   (chain_valid[NUM_TERMS-1]),
        .pipe_en      (pipe_en),
        .cosine       (cosine),
        .cosine_valid (cosine_valid),
        .cosine_ready (cosine_ready)
    );

    assign angle_ready = pipe_en;

endmodule

`default_nettype wire

// File: hw/rtl/cts_square.sv
// front end: angle magnitude, exact square and rounding of x squared
`default_nettype none

module cts_square (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        angle_valid,
    input  logic [cts_pkg::ANGLE_W-1:0] angle,
    output cts_pkg::term_t              term,
    output logic                        term_valid
);

    logic [1:0]                     vld_reg;
    logic [cts_pkg::ANGLE_W-1:0]    ux_next;
    logic [cts_pkg::SQ_W-1:0]       sq_next;
    logic [cts_pkg::SQ_W-1:0]       sq_reg;
    logic [cts_pkg::SQ_W-1:0]       rnd_next;
    cts_pkg::term_t                 term_next;
    cts_pkg::term_t                 term_reg;

    always_comb
    begin
        ux_next = angle[cts_pkg::ANGLE_W-1] ? (~angle + 1'b1) : angle;
        sq_next = cts_pkg::SQ_W'(ux_next) * cts_pkg::SQ_W'(ux_next);
    end

    always_comb
    begin
        rnd_next       = sq_reg + (cts_pkg::SQ_W'(1) << (cts_pkg::SQ_SHIFT - 1));
        term_next.neg  = 1'b0;
        term_next.mag  = cts_pkg::ONE_MAG;
        term_next.y    = rnd_next[cts_pkg::SQ_SHIFT +: cts_pkg::Y_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[0], angle_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg   <= sq_next;
            term_reg <= term_next;
        end
    end

    assign term       = term_reg;
    assign term_valid = vld_reg[1];

endmodule

`default_nettype wire

// File: hw/rtl/cts_step.sv
// one horner step: t = 1 - round(round(y*t) / ((2k+1)(2k+2))), eight stages
`default_nettype none

module cts_step #(
    parameter int K = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  cts_pkg::term_t term_in,
    input  logic           term_in_valid,
    output cts_pkg::term_t term_out,
    output logic           term_out_valid
);

    localparam int unsigned DIV  = (2 * K + 1) * (2 * K + 2);
    localparam int unsigned HALF = DIV / 2;
    localparam int          SH   = cts_pkg::V_W + $clog2(DIV);
    localparam logic [cts_pkg::RECIP_W-1:0] RECIP =
        cts_pkg::RECIP_W'(((64'd1 << SH) + 64'(DIV - 1)) / 64'(DIV));

    localparam int PP_LL_W = cts_pkg::Y_LO_W + cts_pkg::MAG_LO_W;
    localparam int PP_LH_W = cts_pkg::Y_LO_W + cts_pkg::MAG_HI_W;
    localparam int PP_HL_W = cts_pkg::Y_HI_W + cts_pkg::MAG_LO_W;
    localparam int PP_HH_W = cts_pkg::Y_HI_W + cts_pkg::MAG_HI_W;
    localparam int LO_W    = 2 * cts_pkg::DIG_W;

    logic [7:0] vld_reg;

    // stage 1: partial products
    logic [PP_LL_W-1:0]       pp_ll_reg;
    logic [PP_LH_W-1:0]       pp_lh_reg;
    logic [PP_HL_W-1:0]       pp_hl_reg;
    logic [PP_HH_W-1:0]       pp_hh_reg;
    logic [7:1]               neg_reg;
    logic [cts_pkg::Y_W-1:0]  y_reg [1:7];

    // stage 2: rounded product plus half divisor
    logic [cts_pkg::SUM_W-1:0] sum_next;
    logic [cts_pkg::N_W-1:0]   n_reg;

    // stages 3 to 7: division one 21 bit digit at a time
    logic [cts_pkg::V_W-1:0]     v1_next;
    logic [cts_pkg::PRODV_W-1:0] p1_next;
    logic [cts_pkg::V_W-1:0]     v1_reg;
    logic [cts_pkg::DIG_W-1:0]   q1_reg [3:7];
    logic [LO_W-1:0]             lo_reg [3:4];
    logic [cts_pkg::V_W-1:0]     r1_full_next;
    logic [cts_pkg::REM_W-1:0]   r1_reg;
    logic [cts_pkg::V_W-1:0]     v2_next;
    logic [cts_pkg::PRODV_W-1:0] p2_next;
    logic [cts_pkg::V_W-1:0]     v2_reg;
    logic [cts_pkg::DIG_W-1:0]   q2_reg [5:7];
    logic [cts_pkg::DIG_W-1:0]   dig3_reg [5:6];
    logic [cts_pkg::V_W-1:0]     r2_full_next;
    logic [cts_pkg::REM_W-1:0]   r2_reg;
    logic [cts_pkg::V_W-1:0]     v3_next;
    logic [cts_pkg::PRODV_W-1:0] p3_next;
    logic [cts_pkg::DIG_W-1:0]   q3_reg;

    // stage 8: new t
    logic [cts_pkg::N_W-1:0] q_full;
    cts_pkg::term_t          term_next;
    cts_pkg::term_t          term_reg;

    always_comb
    begin
        sum_next = cts_pkg::SUM_W'(pp_ll_reg)
                 + (cts_pkg::SUM_W'(pp_lh_reg) << cts_pkg::MAG_LO_W)
                 + (cts_pkg::SUM_W'(pp_hl_reg) << cts_pkg::Y_LO_W)
                 + (cts_pkg::SUM_W'(pp_hh_reg) << (cts_pkg::Y_LO_W + cts_pkg::MAG_LO_W))
                 + (cts_pkg::SUM_W'(1) << (cts_pkg::FRAC_W - 1))
                 + (cts_pkg::SUM_W'(HALF) << cts_pkg::FRAC_W);
    end

    always_comb
    begin
        v1_next      = cts_pkg::V_W'(n_reg[LO_W +: cts_pkg::DIG_W]);
        p1_next      = cts_pkg::PRODV_W'(v1_next) * cts_pkg::PRODV_W'(RECIP);
        r1_full_next = v1_reg - cts_pkg::V_W'(q1_reg[3]) * cts_pkg::V_W'(DIV);
        v2_next      = {r1_reg, lo_reg[4][cts_pkg::DIG_W +: cts_pkg::DIG_W]};
        p2_next      = cts_pkg::PRODV_W'(v2_next) * cts_pkg::PRODV_W'(RECIP);
        r2_full_next = v2_reg - cts_pkg::V_W'(q2_reg[5]) * cts_pkg::V_W'(DIV);
        v3_next      = {r2_reg, dig3_reg[6]};
        p3_next      = cts_pkg::PRODV_W'(v3_next) * cts_pkg::PRODV_W'(RECIP);
    end

    always_comb
    begin
        q_full       = {q1_reg[7], q2_reg[7], q3_reg};
        term_next.y  = y_reg[7];
        if (neg_reg[7])
        begin
            term_next.neg = 1'b0;
            term_next.mag = cts_pkg::MAG_W'(q_full + cts_pkg::ONE_N);
        end
        else if (q_full > cts_pkg::ONE_N)
        begin
            term_next.neg = 1'b1;
            term_next.mag = cts_pkg::MAG_W'(q_full - cts_pkg::ONE_N);
        end
        else
        begin
            term_next.neg = 1'b0;
            term_next.mag = cts_pkg::MAG_W'(cts_pkg::ONE_N - q_full);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[6:0], term_in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg <= PP_LL_W'(term_in.y[cts_pkg::Y_LO_W-1:0])
                       * PP_LL_W'(term_in.mag[cts_pkg::MAG_LO_W-1:0]);
            pp_lh_reg <= PP_LH_W'(term_in.y[cts_pkg::Y_LO_W-1:0])
                       * PP_LH_W'(term_in.mag[cts_pkg::MAG_W-1:cts_pkg::MAG_LO_W]);
            pp_hl_reg <= PP_HL_W'(term_in.y[cts_pkg::Y_W-1:cts_pkg::Y_LO_W])
                       * PP_HL_W'(term_in.mag[cts_pkg::MAG_LO_W-1:0]);
            pp_hh_reg <= PP_HH_W'(term_in.y[cts_pkg::Y_W-1:cts_pkg::Y_LO_W])
                       * PP_HH_W'(term_in.mag[cts_pkg::MAG_W-1:cts_pkg::MAG_LO_W]);
            neg_reg   <= {neg_reg[6:1], term_in.neg};
            y_reg[1]  <= term_in.y;
            for (int i = 2; i < 8; i++)
            begin
                y_reg[i] <= y_reg[i-1];
            end

            n_reg <= sum_next[cts_pkg::FRAC_W +: cts_pkg::N_W];

            v1_reg    <= v1_next;
            q1_reg[3] <= p1_next[SH +: cts_pkg::DIG_W];
            lo_reg[3] <= n_reg[LO_W-1:0];

            r1_reg    <= r1_full_next[cts_pkg::REM_W-1:0];
            q1_reg[4] <= q1_reg[3];
            lo_reg[4] <= lo_reg[3];

            v2_reg      <= v2_next;
            q2_reg[5]   <= p2_next[SH +: cts_pkg::DIG_W];
            q1_reg[5]   <= q1_reg[4];
            dig3_reg[5] <= lo_reg[4][cts_pkg::DIG_W-1:0];

            r2_reg      <= r2_full_next[cts_pkg::REM_W-1:0];
            q2_reg[6]   <= q2_reg[5];
            q1_reg[6]   <= q1_reg[5];
            dig3_reg[6] <= dig3_reg[5];

            q3_reg    <= p3_next[SH +: cts_pkg::DIG_W];
            q2_reg[7] <= q2_reg[6];
            q1_reg[7] <= q1_reg[6];

            term_reg <= term_next;
        end
    end

    assign term_out       = term_reg;
    assign term_out_valid = vld_reg[7];

endmodule

`default_nettype wire

// File: hw/rtl/cts_round.sv
// final rounding, saturation and output register with skid slot
`default_nettype none

module cts_round #(
    parameter int OUT_FRAC_BITS = 30
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cts_pkg::term_t            term,
    input  logic                      term_valid,
    output logic                      pipe_en,
    output logic [cts_pkg::COS_W-1:0] cosine,
    output logic                      cosine_valid,
    input  logic                      cosine_ready
);

    localparam int RSH   = cts_pkg::FRAC_W - OUT_FRAC_BITS;
    localparam int RND_W = cts_pkg::MAG_W + 1;

    logic [RND_W-1:0]         rnd;
    logic [RND_W-1:0]         mr;
    logic [cts_pkg::COS_W-1:0] cos_next;
    logic                      take;
    logic                      out_valid_reg;
    logic [cts_pkg::COS_W-1:0] out_reg;
    logic                      skid_valid_reg;
    logic [cts_pkg::COS_W-1:0] skid_reg;

    always_comb
    begin
        rnd = RND_W'(term.mag) + (RND_W'(1) << (RSH - 1));
        mr  = rnd >> RSH;
        if (term.neg)
        begin
            if (mr > RND_W'(cts_pkg::MIN_NEG))
                cos_next = cts_pkg::MIN_NEG;
            else
                cos_next = ~mr[cts_pkg::COS_W-1:0] + 1'b1;
        end
        else
        begin
            if (mr > RND_W'(cts_pkg::MAX_POS))
                cos_next = cts_pkg::MAX_POS;
            else
                cos_next = mr[cts_pkg::COS_W-1:0];
        end
    end

    assign take    = !out_valid_reg || cosine_ready;
    assign pipe_en = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= term_valid;
            end
        end
        else if (term_valid && pipe_en)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= skid_valid_reg ? skid_reg : cos_next;
        end
        else if (term_valid && pipe_en)
        begin
            skid_reg <= cos_next;
        end
    end

    assign cosine       = out_reg;
    assign cosine_valid = out_valid_reg;

endmodule

`default_nettype wire
